// File: hw/rtl/utf8s_pkg.sv
// ----------------------------------------------------------------------------
// utf8s_pkg
// Shared types, codes and tables of the identifier sanitizer.
// ----------------------------------------------------------------------------
package utf8s_pkg;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   localparam logic [6:0] CHAR_USCORE = 7'h5F;
   localparam logic [6:0] CHAR_NUL    = 7'h00;
   localparam int         UNNAMED_LAST = 6;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_CHARS   = 2'd0;
   localparam kind_type KIND_MARK    = 2'd1;
   localparam kind_type KIND_UNNAMED = 2'd2;

   // one command from the front: a kept character group, an end marker or the fallback
   typedef struct packed {
      kind_type   kind;
      logic       sep;
      logic [6:0] c0;
      logic [6:0] c1;
      logic       two;
      logic       done;
   } cmd_type;

   typedef struct packed {
      logic       hit;
      logic [6:0] c0;
      logic [6:0] c1;
      logic       two;
   } pair_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } qstat_type;

   function automatic pair_type mk1(input logic [7:0] c);
      pair_type r;
      r.hit = 1'b1;
      r.c0  = c[6:0];
      r.c1  = CHAR_NUL;
      r.two = 1'b0;
      return r;
   endfunction

   function automatic pair_type mk2(input logic [7:0] a, input logic [7:0] b);
      pair_type r;
      r.hit = 1'b1;
      r.c0  = a[6:0];
      r.c1  = b[6:0];
      r.two = 1'b1;
      return r;
   endfunction

   // transliteration of a raw two-byte sequence
   function automatic pair_type lookup_pair(input logic [7:0] lead, input logic [7:0] second);
      pair_type r;
      logic [5:0] idx;
      r   = '0;
      idx = second[5:0];
      if (lead == 8'hC3 && second[7:6] == 2'b10) begin
         unique case (idx) inside
            [6'd0:6'd3], 6'd5: r = mk1("A");
            6'd4, 6'd6:        r = mk2("A", "e");
            6'd7:              r = mk1("C");
            [6'd8:6'd11]:      r = mk1("E");
            [6'd12:6'd15]:     r = mk1("I");
            6'd17:             r = mk1("N");
            [6'd18:6'd21], 6'd24: r = mk1("O");
            6'd22:             r = mk2("O", "e");
            [6'd25:6'd27]:     r = mk1("U");
            6'd28:             r = mk2("U", "e");
            6'd29:             r = mk1("Y");
            6'd31:             r = mk2("s", "s");
            [6'd32:6'd35], 6'd37: r = mk1("a");
            6'd36, 6'd38:      r = mk2("a", "e");
            6'd39:             r = mk1("c");
            [6'd40:6'd43]:     r = mk1("e");
            [6'd44:6'd47]:     r = mk1("i");
            6'd49:             r = mk1("n");
            [6'd50:6'd53], 6'd56: r = mk1("o");
            6'd54:             r = mk2("o", "e");
            [6'd57:6'd59]:     r = mk1("u");
            6'd60:             r = mk2("u", "e");
            6'd61, 6'd63:      r = mk1("y");
            default:           r = '0;
         endcase
      end else if (lead == 8'hC5 && second == 8'h92) begin
         r = mk2("O", "e");
      end else if (lead == 8'hC5 && second == 8'h93) begin
         r = mk2("o", "e");
      end
      return r;
   endfunction

   function automatic logic [6:0] unnamed_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = "U";
         3'd1:    c = "n";
         3'd2:    c = "n";
         3'd3:    c = "a";
         3'd4:    c = "m";
         3'd5:    c = "e";
         default: c = "d";
      endcase
      return c[6:0];
   endfunction

endpackage

// File: hw/rtl/utf8s_front.sv
// ----------------------------------------------------------------------------
// utf8s_front
// Takes one byte a cycle while the queue has room, tracks sequences and separators, issues commands.
// ----------------------------------------------------------------------------
module utf8s_front
   import utf8s_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_tvalid,
   output logic      req_tready,
   input  logic [7:0] req_tdata,   // in_byte [7:0]
   input  logic      req_tlast,    // end_of_name
   input  qstat_type q_status,
   output logic      push,
   output cmd_type   cmd
);

   logic       sep_ff, sep_in;
   logic       any_ff, any_in;
   logic [1:0] left_ff, left_in;
   logic [7:0] lead_ff, lead_in;
   logic       two_ff, two_in;

   logic       accept;
   logic       keep;
   logic       mark;
   logic [1:0] left_dec;
   logic [7:0] b;
   logic       end_n;
   logic       alnum;
   pair_type   kc;
   pair_type   pr;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign end_n      = req_tlast;
   assign left_dec   = left_ff - 2'd1;
   assign pr         = lookup_pair(lead_ff, b);
   assign alnum      = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                       (b >= 8'h61 && b <= 8'h7A);

   always_comb begin
      keep    = 1'b0;
      mark    = 1'b0;
      kc      = '0;
      left_in = left_ff;
      lead_in = lead_ff;
      two_in  = two_ff;
      if (left_ff != 2'd0) begin
         left_in = left_dec;
         if (left_dec == 2'd0) begin
            if (two_ff && pr.hit) begin
               keep = 1'b1;
               kc   = pr;
            end else begin
               mark = 1'b1;
            end
         end else if (end_n) begin
            mark = 1'b1;
         end
      end else if (!b[7]) begin
         if (alnum) begin
            keep = 1'b1;
            kc   = mk1(b);
         end else begin
            mark = 1'b1;
         end
      end else if (b[7:5] == 3'b110) begin
         left_in = 2'd1;
         lead_in = b;
         two_in  = 1'b1;
         mark    = end_n;
      end else if (b[7:4] == 4'b1110) begin
         left_in = 2'd2;
         lead_in = b;
         two_in  = 1'b0;
         mark    = end_n;
      end else if (b[7:3] == 5'b11110) begin
         left_in = 2'd3;
         lead_in = b;
         two_in  = 1'b0;
         mark    = end_n;
      end else begin
         mark = 1'b1;
      end
   end

   always_comb begin
      cmd.sep  = sep_ff;
      cmd.c0   = kc.c0;
      cmd.c1   = kc.c1;
      cmd.two  = kc.two;
      cmd.done = end_n;
      if (keep) begin
         cmd.kind = KIND_CHARS;
      end else if (any_ff) begin
         cmd.kind = KIND_MARK;
      end else begin
         cmd.kind = KIND_UNNAMED;
      end
      push = accept && (keep || end_n);
      sep_in = sep_ff;
      any_in = any_ff;
      if (keep) begin
         sep_in = 1'b0;
         any_in = 1'b1;
      end else if (mark && any_ff) begin
         sep_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff  <= 1'b0;
         any_ff  <= 1'b0;
         left_ff <= 2'd0;
         lead_ff <= 8'd0;
         two_ff  <= 1'b0;
      end else if (accept) begin
         if (end_n) begin
            sep_ff  <= 1'b0;
            any_ff  <= 1'b0;
            left_ff <= 2'd0;
            lead_ff <= 8'd0;
            two_ff  <= 1'b0;
         end else begin
            sep_ff  <= sep_in;
            any_ff  <= any_in;
            left_ff <= left_in;
            lead_ff <= lead_in;
            two_ff  <= two_in;
         end
      end
   end

endmodule

// File: hw/rtl/utf8s_queue.sv
// ----------------------------------------------------------------------------
// utf8s_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module utf8s_queue
   import utf8s_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cmd_type   cmd_in,
   input  logic      pop,
   output cmd_type   head,
   output qstat_type q_status
);

   cmd_type        mem_ff [QDEPTH];
   logic [QAW-1:0] wr_ff;
   logic [QAW-1:0] rd_ff;
   logic [QAW:0]   count_ff, count_in;
   logic           do_pop;

   assign q_status.not_empty = count_ff != '0;
   assign q_status.full      = count_ff == (QAW+1)'(QDEPTH);
   assign head               = mem_ff[rd_ff];
   assign do_pop             = pop && q_status.not_empty;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// File: hw/rtl/utf8s_back.sv
// ----------------------------------------------------------------------------
// utf8s_back
// Expands queued commands into result characters, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module utf8s_back
   import utf8s_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   head,
   input  qstat_type q_status,
   output logic      pop,
   output logic      rsp_tvalid,
   input  logic      rsp_tready,
   output logic [7:0] rsp_tdata,   // out_char [6:0], zero [7]
   output logic      rsp_tuser,    // has_char
   output logic      rsp_tlast     // name_done
);

   logic       valid_ff;
   logic [6:0] char_ff;
   logic       has_ff;
   logic       done_ff;
   logic [2:0] step_ff;

   logic       load;
   logic [2:0] sel;
   logic [6:0] char_in;
   logic       has_in;
   logic       last;

   assign load = q_status.not_empty && (!valid_ff || rsp_tready);
   assign sel  = step_ff + {2'b00, ~head.sep};

   always_comb begin
      char_in = CHAR_NUL;
      has_in  = 1'b1;
      last    = 1'b1;
      unique case (head.kind)
         KIND_CHARS: begin
            case (sel)
               3'd0:    char_in = CHAR_USCORE;
               3'd1:    char_in = head.c0;
               default: char_in = head.c1;
            endcase
            last = sel == (head.two ? 3'd2 : 3'd1);
         end
         KIND_UNNAMED: begin
            char_in = unnamed_char(step_ff);
            last    = step_ff == 3'(UNNAMED_LAST);
         end
         default: begin
            has_in = 1'b0;
         end
      endcase
   end

   assign pop = load && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= 3'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            step_ff  <= last ? 3'd0 : step_ff + 3'd1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         has_ff  <= has_in;
         done_ff <= last && (head.done || head.kind != KIND_CHARS);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, char_ff};
   assign rsp_tuser  = has_ff;
   assign rsp_tlast  = done_ff;

`ifndef NO_ASSERTIONS
   a_marker_bare: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !has_ff |-> char_ff == CHAR_NUL && done_ff)
      else $error("end marker carries a character or lacks done");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 3'(UNNAMED_LAST))
      else $error("step counter out of range");
   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      !q_status.not_empty |-> step_ff == 3'd0)
      else $error("step counter left mid command with empty queue");
`endif

endmodule

// File: hw/rtl/utf8_identifier_sanitizer.sv
// ----------------------------------------------------------------------------
// utf8_identifier_sanitizer
// UTF-8 name bytes in, ASCII identifier characters out.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the queue has room; each result character
// leaves at one per cycle unless the output stalls. A byte may produce up to
// three characters (separator plus a two-letter transliteration) and a name
// with nothing kept produces seven ("Unnamed"), so input bytes keep flowing at
// full rate until the four-entry command queue between the byte classifier
// and the character expander fills; throughput over a burst is then set by
// the expander's one character per cycle. Queue and output are registered.
module utf8_identifier_sanitizer
   import utf8s_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte [7:0]
   input  logic       req_tlast,   // end_of_name
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_char [6:0], zero [7]
   output logic       rsp_tuser,   // has_char
   output logic       rsp_tlast    // name_done
);

   qstat_type q_status;
   logic      push;
   logic      pop;
   cmd_type   cmd;
   cmd_type   head;

   utf8s_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .cmd        (cmd)
   );

   utf8s_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .cmd_in   (cmd),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   utf8s_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
